/* rtl/core/pwdb_pkg.sv */
// Shared constants, register map and configuration bundle for the PID block.
package pwdb_pkg;

   // Register field width and configuration bus geometry
   localparam int CFG_W       = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 5;
   localparam int DRIVE_W     = 17;

   // Defaults for the top-level parameters
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   // Register indexes (word address)
   localparam logic [2:0] REG_SETPOINT     = 3'd0;
   localparam logic [2:0] REG_GAIN_P       = 3'd1;
   localparam logic [2:0] REG_GAIN_I       = 3'd2;
   localparam logic [2:0] REG_GAIN_D       = 3'd3;
   localparam logic [2:0] REG_DEAD_ZONE    = 3'd4;
   localparam logic [2:0] REG_INTEGRAL_CAP = 3'd5;
   localparam logic [2:0] REG_OUTPUT_CAP   = 3'd6;

   // Unsigned gains and limits handed from the register file to the datapath
   typedef struct packed {
      logic [CFG_W-1:0] gain_p;
      logic [CFG_W-1:0] gain_i;
      logic [CFG_W-1:0] gain_d;
      logic [CFG_W-1:0] dead_zone;
      logic [CFG_W-1:0] integral_cap;
      logic [CFG_W-1:0] output_cap;
   } cfg_type;

endpackage

/* rtl/core/pwdb_csr.sv */
// APB-style configuration register file for the PID block.
module pwdb_csr
   import pwdb_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ADDR_W-1:0]              paddr,
   input  logic [DATA_W-1:0]              pwdata,
   output logic [DATA_W-1:0]              prdata,
   output logic signed [SAMPLE_WIDTH-1:0] setpoint,
   output cfg_type                        cfg
);

   logic signed [SAMPLE_WIDTH-1:0] setpoint_ff;
   cfg_type                        cfg_ff;
   logic [2:0]                     index;
   logic                           wr_en;

   assign index = paddr[ADDR_W-1:2];
   assign wr_en = psel & penable & pwrite;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         cfg_ff      <= '0;
      end else if (wr_en) begin
         unique case (index)
            REG_SETPOINT:     setpoint_ff         <= pwdata[SAMPLE_WIDTH-1:0];
            REG_GAIN_P:       cfg_ff.gain_p       <= pwdata[CFG_W-1:0];
            REG_GAIN_I:       cfg_ff.gain_i       <= pwdata[CFG_W-1:0];
            REG_GAIN_D:       cfg_ff.gain_d       <= pwdata[CFG_W-1:0];
            REG_DEAD_ZONE:    cfg_ff.dead_zone    <= pwdata[CFG_W-1:0];
            REG_INTEGRAL_CAP: cfg_ff.integral_cap <= pwdata[CFG_W-1:0];
            REG_OUTPUT_CAP:   cfg_ff.output_cap   <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux, setpoint sign-extended
   always_comb begin
      unique case (index)
         REG_SETPOINT:     prdata = DATA_W'(setpoint_ff);
         REG_GAIN_P:       prdata = DATA_W'(cfg_ff.gain_p);
         REG_GAIN_I:       prdata = DATA_W'(cfg_ff.gain_i);
         REG_GAIN_D:       prdata = DATA_W'(cfg_ff.gain_d);
         REG_DEAD_ZONE:    prdata = DATA_W'(cfg_ff.dead_zone);
         REG_INTEGRAL_CAP: prdata = DATA_W'(cfg_ff.integral_cap);
         REG_OUTPUT_CAP:   prdata = DATA_W'(cfg_ff.output_cap);
         default:          prdata = '0;
      endcase
   end

   assign setpoint = setpoint_ff;
   assign cfg      = cfg_ff;

endmodule

/* rtl/core/pwdb_front.sv */
// Input register, error, deadband test and the three gain products.
module pwdb_front
   import pwdb_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int ERR_W  = SAMPLE_WIDTH + 1,
   localparam int PROD_W = SAMPLE_WIDTH + CFG_W + 1,
   localparam int DPRD_W = SAMPLE_WIDTH + CFG_W + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_measured,
   input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
   input  cfg_type                        cfg,
   input  logic                           down_ready,
   output logic                           prod_valid,
   output logic                           prod_hit,
   output logic signed [PROD_W-1:0]       prod_p,
   output logic signed [PROD_W-1:0]       prod_i,
   output logic signed [DPRD_W-1:0]       prod_d
);

   localparam int DIF_W = SAMPLE_WIDTH + 2;
   localparam int CMP_W = (ERR_W > CFG_W) ? ERR_W : CFG_W;

   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] meas_ff;
   logic                           pr_valid_ff;
   logic                           hit_ff;
   logic signed [PROD_W-1:0]       p_ff, p_in;
   logic signed [PROD_W-1:0]       i_ff, i_in;
   logic signed [DPRD_W-1:0]       d_ff, d_in;
   logic signed [ERR_W-1:0]        prev_err_ff;
   logic signed [ERR_W-1:0]        err;
   logic [ERR_W-1:0]               mag;
   logic                           hit_in;
   logic signed [DIF_W-1:0]        diff;
   logic signed [PROD_W-1:0]       err_x, gp_x, gi_x;
   logic signed [DPRD_W-1:0]       diff_x, gd_x;
   logic                           pr_ready;
   logic                           in_ready;
   logic                           move;

   // Stall chain: each stage takes a beat when empty or when it drains
   assign pr_ready  = ~pr_valid_ff | down_ready;
   assign in_ready  = ~in_valid_ff | pr_ready;
   assign move      = in_valid_ff & pr_ready;
   assign req_ready = in_ready;

   // Error and its magnitude against the deadband
   always_comb begin
      err    = ERR_W'(setpoint) - ERR_W'(meas_ff);
      mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      hit_in = CMP_W'(mag) > CMP_W'(cfg.dead_zone);
      diff   = DIF_W'(err) - DIF_W'(prev_err_ff);
   end

   // Gain products; gains are unsigned so they go in zero-extended
   always_comb begin
      err_x  = PROD_W'(err);
      gp_x   = PROD_W'({1'b0, cfg.gain_p});
      gi_x   = PROD_W'({1'b0, cfg.gain_i});
      diff_x = DPRD_W'(diff);
      gd_x   = DPRD_W'({1'b0, cfg.gain_d});
      p_in   = gp_x * err_x;
      i_in   = gi_x * err_x;
      d_in   = gd_x * diff_x;
   end

   // Valid flags and the stored error
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pr_valid_ff <= 1'b0;
         prev_err_ff <= '0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (pr_ready) begin
            pr_valid_ff <= in_valid_ff;
         end
         if (move) begin
            prev_err_ff <= err;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         meas_ff <= req_measured;
      end
      if (move) begin
         hit_ff <= hit_in;
         p_ff   <= p_in;
         i_ff   <= i_in;
         d_ff   <= d_in;
      end
   end

   assign prod_valid = pr_valid_ff;
   assign prod_hit   = hit_ff;
   assign prod_p     = p_ff;
   assign prod_i     = i_ff;
   assign prod_d     = d_ff;

endmodule

/* rtl/core/pwdb_back.sv */
// Integral update with clamp, output sum, saturation and result register.
module pwdb_back
   import pwdb_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   localparam int PROD_W = SAMPLE_WIDTH + CFG_W + 1,
   localparam int DPRD_W = SAMPLE_WIDTH + CFG_W + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     prod_valid,
   input  logic                     prod_hit,
   input  logic signed [PROD_W-1:0] prod_p,
   input  logic signed [PROD_W-1:0] prod_i,
   input  logic signed [DPRD_W-1:0] prod_d,
   output logic                     up_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DRIVE_W-1:0] rsp_drive
);

   localparam int ACC_W = GAIN_FRAC_BITS + CFG_W + 1;
   localparam int BIG_W = (DPRD_W > ACC_W) ? DPRD_W : ACC_W;
   localparam int TOT_W = BIG_W + 2;

   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DRIVE_W-1:0] held_ff;
   logic                      out_valid_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic signed [TOT_W-1:0]   ilim, olim;
   logic signed [TOT_W-1:0]   acc_sum, acc_clip;
   logic signed [TOT_W-1:0]   tot, tot_clip;
   logic [TOT_W-1:0]          tmag, tsh;
   logic [DRIVE_W-1:0]        qmag;
   logic signed [DRIVE_W-1:0] drive_new;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      take;

   assign up_ready = ~out_valid_ff | rsp_ready;
   assign take     = prod_valid & up_ready;

   // Limits scaled into the fixed-point domain
   assign ilim = TOT_W'(cfg.integral_cap) << GAIN_FRAC_BITS;
   assign olim = TOT_W'(cfg.output_cap) << GAIN_FRAC_BITS;

   // Anti-windup integral and clamped sum of the three terms
   always_comb begin
      acc_sum = TOT_W'(acc_ff) + TOT_W'(prod_i);
      if (acc_sum > ilim) begin
         acc_clip = ilim;
      end else if (acc_sum < -ilim) begin
         acc_clip = -ilim;
      end else begin
         acc_clip = acc_sum;
      end
      tot = TOT_W'(prod_p) + acc_clip + TOT_W'(prod_d);
      if (tot > olim) begin
         tot_clip = olim;
      end else if (tot < -olim) begin
         tot_clip = -olim;
      end else begin
         tot_clip = tot;
      end
      acc_in = acc_clip[ACC_W-1:0];
   end

   // Drop the fraction bits, rounding toward zero
   always_comb begin
      tmag      = tot_clip[TOT_W-1] ? TOT_W'(-tot_clip) : TOT_W'(tot_clip);
      tsh       = tmag >> GAIN_FRAC_BITS;
      qmag      = tsh[DRIVE_W-1:0];
      drive_new = tot_clip[TOT_W-1] ? DRIVE_W'(-qmag) : DRIVE_W'(qmag);
      drive_in  = prod_hit ? drive_new : held_ff;
   end

   // Controller state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            out_valid_ff <= prod_valid;
         end
         if (take && prod_hit) begin
            acc_ff  <= acc_in;
            held_ff <= drive_new;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_drive = drive_ff;

endmodule

/* rtl/core/pid_with_deadband_clamps_unit.sv */
// Top level of the PID controller with deadband and anti-windup clamps.
//
//   port group   direction  beat / access
//   req_*        in         one measurement per beat, valid/ready
//   rsp_*        out        one saturated drive per measurement, valid/ready
//   APB          in/out     seven 32-bit registers at 4*index, pready tied high
//
// One measurement per cycle sustained while rsp_ready is high; a beat's result
// passes the input register, product register and result register in turn.
// The three gain multipliers sit in one stage; the integral feedback is
// closed in the next, so each stage is a single pass and never iterates.
// Synchronous reset clears config registers, controller state and valid flags.
// Backpressure on rsp_ready stalls stages only as far back as they are full.
module pid_with_deadband_clamps_unit
   import pwdb_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_measured,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [DRIVE_W-1:0]      rsp_drive,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ADDR_W-1:0]              paddr,
   input  logic [DATA_W-1:0]              pwdata,
   output logic [DATA_W-1:0]              prdata,
   output logic                           pready
);

   localparam int PROD_W = SAMPLE_WIDTH + CFG_W + 1;
   localparam int DPRD_W = SAMPLE_WIDTH + CFG_W + 2;

   logic signed [SAMPLE_WIDTH-1:0] setpoint;
   cfg_type                        cfg;
   logic                           back_ready;
   logic                           prod_valid;
   logic                           prod_hit;
   logic signed [PROD_W-1:0]       prod_p;
   logic signed [PROD_W-1:0]       prod_i;
   logic signed [DPRD_W-1:0]       prod_d;

   assign pready = 1'b1;

   // Configuration registers
   pwdb_csr #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .setpoint (setpoint),
      .cfg      (cfg)
   );

   // Error and gain products
   pwdb_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_measured (req_measured),
      .setpoint     (setpoint),
      .cfg          (cfg),
      .down_ready   (back_ready),
      .prod_valid   (prod_valid),
      .prod_hit     (prod_hit),
      .prod_p       (prod_p),
      .prod_i       (prod_i),
      .prod_d       (prod_d)
   );

   // Integral, saturation and result register
   pwdb_back #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_hit   (prod_hit),
      .prod_p     (prod_p),
      .prod_i     (prod_i),
      .prod_d     (prod_d),
      .up_ready   (back_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_drive  (rsp_drive)
   );

endmodule
